### design/sis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants of the interpolation sweep unit.
// ----------------------------------------------------------------------------
package sis_pkg;

   localparam int unsigned DataWidth   = 16;
   localparam int unsigned IndexWidth  = 5;
   localparam int unsigned RecordWidth = 128;
   localparam logic [4:0]  IndexMask   = 5'h1f;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // queued command from the front part to the back part
   typedef struct packed {
      logic        kind;
      logic [7:0]  index;
      logic [15:0] load_x;
      logic [15:0] load_y;
      logic [15:0] load_z;
      logic [15:0] goal_x;
      logic [15:0] goal_y;
      logic [15:0] goal_z;
      logic [15:0] steps_xy;
      logic [15:0] steps_z;
   } cmd_type;

   // one result transaction
   typedef struct packed {
      logic        last;
      logic [15:0] new_z;
      logic [15:0] new_y;
      logic [15:0] new_x;
      logic [4:0]  moved_index;
   } rsp_type;

endpackage

### design/sis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_ram
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
// ----------------------------------------------------------------------------
module sis_ram #(
   parameter int unsigned Width = 128,
   parameter int unsigned Depth = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                          wr_data,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                          rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/sis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_front
// Accepts input transactions and queues them as commands for the back part.
// ----------------------------------------------------------------------------
module sis_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sis_pkg::cmd_type in_cmd,
   output logic             q_valid,
   input  logic             q_ready,
   output sis_pkg::cmd_type q_cmd
);
   import sis_pkg::*;

   // two-entry queue
   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_cmd    = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end
endmodule

### design/sis_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_div
// Restoring signed divider, 17-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module sis_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [16:0] dividend,
   input  logic signed [15:0] divisor,
   output logic               done,
   output logic signed [16:0] quotient
);
   logic [16:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [15:0] den_ff, den_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [17:0] trial;

   assign trial    = {rem_ff, quo_ff[16]} - {2'b00, den_ff};
   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[16] ? 17'(-dividend) : 17'(dividend);
         den_in  = divisor[15] ? 16'(-divisor) : 16'(divisor);
         neg_in  = dividend[16] ^ divisor[15];
         busy_in = 1'b1;
         cnt_in  = 5'd0;
      end else if (busy_ff) begin
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[16]};
            quo_in = {quo_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end
endmodule

### design/sis_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_back
// Executes loads and sweeps over the record memory, one record at a time.
// ----------------------------------------------------------------------------
module sis_back #(
   parameter int unsigned RecordCount = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  sis_pkg::cmd_type q_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sis_pkg::rsp_type rsp_data
);
   import sis_pkg::*;

   localparam int unsigned AW = (RecordCount > 1) ? $clog2(RecordCount) : 1;
   localparam int unsigned CW = AW + 1;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_READ  = 4'd2;
   localparam logic [3:0] ST_WAIT  = 4'd3;
   localparam logic [3:0] ST_DX    = 4'd4;
   localparam logic [3:0] ST_DY    = 4'd5;
   localparam logic [3:0] ST_DZ    = 4'd6;
   localparam logic [3:0] ST_WRITE = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;
   localparam logic [3:0] ST_FLUSH = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [RecordWidth-1:0] rec_ff, rec_in, rd_data, wr_data;
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic             moved_ff, moved_in;
   // one held result waits until the next moved record shows whether it is last
   logic             held_ff, held_in;
   rsp_type          held_rec_ff, held_rec_in;
   logic             out_v_ff, out_v_in;
   rsp_type          out_ff, out_in;
   logic             div_start, div_done;
   logic signed [16:0] div_a, div_q;
   logic signed [15:0] div_b;

   // record layout: x y z gx gy gz sxy sz from the low bits up
   logic [15:0] cx, cy, cz, gx, gy, gz, sxy, sz;
   assign {sz, sxy, gz, gy, gx, cz, cy, cx} = rec_ff;

   sis_ram #(.Width(RecordWidth), .Depth(RecordCount)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   sis_div u_div (
      .clock, .reset, .start(div_start), .dividend(div_a), .divisor(div_b),
      .done(div_done), .quotient(div_q)
   );

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign rd_addr   = idx_ff[AW-1:0];

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      rec_in      = rec_ff;
      moved_in    = moved_ff;
      held_in     = held_ff;
      held_rec_in = held_rec_ff;
      out_v_in    = out_v_ff && !rsp_ready;
      out_in      = out_ff;
      q_ready     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[AW-1:0];
      wr_data     = rec_ff;
      div_start   = 1'b0;
      div_a       = 17'(signed'(gx)) - 17'(signed'(cx));
      div_b       = signed'(sxy);
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            idx_in  = idx_ff + CW'(1);
            if (idx_ff == CW'(RecordCount - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_ready = 1'b1;
               if (q_cmd.kind == KIND_LOAD) begin
                  if ({1'b0, q_cmd.index} < 9'(RecordCount)) begin
                     wr_en   = 1'b1;
                     wr_addr = q_cmd.index[AW-1:0];
                     wr_data = {q_cmd.steps_z, q_cmd.steps_xy, q_cmd.goal_z,
                                q_cmd.goal_y, q_cmd.goal_x, q_cmd.load_z,
                                q_cmd.load_y, q_cmd.load_x};
                  end
               end else begin
                  idx_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_WAIT;
         ST_WAIT: begin
            rec_in   = rd_data;
            moved_in = 1'b0;
            state_in = ST_DX;
            if (rd_data[111:96] != 16'd0) begin
               div_start = 1'b1;
               div_a = 17'(signed'(rd_data[63:48])) - 17'(signed'(rd_data[15:0]));
               div_b = signed'(rd_data[111:96]);
            end else begin
               state_in = ST_DZ;
               if (rd_data[127:112] != 16'd0) begin
                  div_start = 1'b1;
                  div_a = 17'(signed'(rd_data[95:80])) - 17'(signed'(rd_data[47:32]));
                  div_b = signed'(rd_data[127:112]);
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_DX: begin
            if (div_done) begin
               rec_in[15:0] = cx + div_q[15:0];
               div_start = 1'b1;
               div_a = 17'(signed'(gy)) - 17'(signed'(cy));
               state_in = ST_DY;
            end
         end
         ST_DY: begin
            if (div_done) begin
               rec_in[31:16]  = cy + div_q[15:0];
               rec_in[111:96] = sxy - 16'd1;
               moved_in = 1'b1;
               if (sz != 16'd0) begin
                  div_start = 1'b1;
                  div_a = 17'(signed'(gz)) - 17'(signed'(cz));
                  div_b = signed'(sz);
                  state_in = ST_DZ;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_DZ: begin
            if (sz == 16'd0) begin
               state_in = ST_WRITE;
            end else if (div_done) begin
               rec_in[47:32]   = cz + div_q[15:0];
               rec_in[127:112] = sz - 16'd1;
               moved_in = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en    = moved_ff;
            state_in = moved_ff ? ST_EMIT : ST_FLUSH;
         end
         ST_EMIT: begin
            // hand over the previous moved record, keep this one
            if (!held_ff || !out_v_in) begin
               if (held_ff) begin
                  out_v_in = 1'b1;
                  out_in   = held_rec_ff;
               end
               held_in     = 1'b1;
               held_rec_in = '{last: 1'b0, new_z: cz, new_y: cy, new_x: cx,
                               moved_index: 5'(idx_ff) & IndexMask};
               state_in    = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (idx_ff != CW'(RecordCount - 1)) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_READ;
            end else if (!held_ff) begin
               state_in = ST_IDLE;
            end else if (!out_v_in) begin
               out_v_in    = 1'b1;
               out_in      = held_rec_ff;
               out_in.last = 1'b1;
               held_in     = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         held_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         moved_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         held_ff  <= held_in;
         out_v_ff <= out_v_in;
         moved_ff <= moved_in;
      end
      rec_ff      <= rec_in;
      held_rec_ff <= held_rec_in;
      out_ff      <= out_in;
   end
endmodule

### design/stepwise_interpolation_sweep_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepwise_interpolation_sweep_unit
// Record bank with per-tick stepwise interpolation toward targets.
// ----------------------------------------------------------------------------
// A load transaction writes one record as the back part takes it from the
// queue. A tick sweeps all RECORD_COUNT records one after another; the x,
// y and z steps of a record with steps left are computed in turn by the
// single shared divider. A sweep stalls while results are held off. After
// reset the record memory is cleared, one record at a time, and no
// transaction is taken from the queue until the clearing is done.
module stepwise_interpolation_sweep_unit #(
   parameter int unsigned RECORD_COUNT = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // record_index, load_x, load_y, load_z, goal_x, goal_y, goal_z,
   // steps_xy, steps_z (5+16*8 bits, padded to 136)
   input  logic [135:0] req_tdata,
   // kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // moved_index, new_x, new_y, new_z (53 bits, padded to 56)
   output logic [55:0]  rsp_tdata,
   output logic         rsp_tlast
);
   import sis_pkg::*;

   cmd_type in_cmd, q_cmd;
   rsp_type rsp;
   logic    q_valid, q_ready;

   assign in_cmd = '{kind: req_tuser, index: {3'b000, req_tdata[4:0]},
                     load_x: req_tdata[20:5],   load_y: req_tdata[36:21],
                     load_z: req_tdata[52:37],  goal_x: req_tdata[68:53],
                     goal_y: req_tdata[84:69],  goal_z: req_tdata[100:85],
                     steps_xy: req_tdata[116:101], steps_z: req_tdata[132:117]};

   sis_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd,
      .q_valid, .q_ready, .q_cmd
   );

   sis_back #(.RecordCount(RECORD_COUNT)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_cmd,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_data(rsp)
   );

   assign rsp_tdata = {3'b000, rsp.new_z, rsp.new_y, rsp.new_x, rsp.moved_index};
   assign rsp_tlast = rsp.last;
endmodule

### design/sis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_checker
// Port-level checks of the interpolation sweep unit.
// ----------------------------------------------------------------------------
module sis_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [55:0]  rsp_tdata,
   input logic         rsp_tlast
);
   // an offered request stays offered until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid)
      else $error("request dropped before acceptance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:53] == 3'b000)
      else $error("result padding not zero");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result right after reset");

   // results of one tick that follow each other back to back run in rising index order
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid
      |-> rsp_tdata[4:0] > $past(rsp_tdata[4:0]))
      else $error("result index order broken");
endmodule

bind stepwise_interpolation_sweep_unit sis_checker u_sis_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast
);
